### sv/hrhp_pkg.sv
// hrhp_pkg: shared types, codes and limits for the http response head parser
// used by http_response_header_parser and its checker; no dependencies
`default_nettype none

package hrhp_pkg;

    localparam int LEN_W = 9;

    // per-token length limits
    localparam logic [LEN_W-1:0] VERSION_MAX = 9'd16;
    localparam logic [LEN_W-1:0] STATUS_MAX  = 9'd8;
    localparam logic [LEN_W-1:0] REASON_MAX  = 9'd64;
    localparam logic [LEN_W-1:0] NAME_MAX    = 9'd64;
    localparam logic [LEN_W-1:0] VALUE_MAX   = 9'd256;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;

    // token kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_VERSION = 3'd1;
    localparam logic [2:0] KIND_STATUS  = 3'd2;
    localparam logic [2:0] KIND_REASON  = 3'd3;
    localparam logic [2:0] KIND_NAME    = 3'd4;
    localparam logic [2:0] KIND_VALUE   = 3'd5;

    // parse status
    localparam logic [1:0] ST_PARSING = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       at_end;
    } hrhp_req_t;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] token_byte;
        logic       pair_done;
        logic [1:0] parse_status;
    } hrhp_res_t;

    // SP, HT, LF, VT, FF, CR
    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_HT);
    endfunction

endpackage

`default_nettype wire

### sv/http_response_header_parser.sv
// http_response_header_parser: byte-serial parser for an http response head
// depends on hrhp_pkg
`default_nettype none

// Usage
//   byte channel: byte_valid / byte_stall / byte_req carry one request per
//   unstalled cycle, either a response byte or an end-of-input marker (at_end).
//   result channel: res_valid / res_stall / res_data return one result per
//   request: the byte tagged by role, a pair-done flag and the parse status.
//   A request's result is registered at the accepting edge, valid right
//   after it. One request is taken per cycle while byte_stall is low; the
//   only state between requests is the phase register, the token length
//   counter and the sticky status, all updated at the accepting edge.
//   byte_stall is high only while the result register holds a result that
//   the receiver stalls, so a held result stalls the byte side in the same
//   cycle and nothing is dropped.
//   Reset clears the result valid flag, puts the parser in the leading
//   whitespace skip, zeroes the length and sets the status to parsing.
//   Once the status is ok or error it stays so until the next reset, and
//   further requests return untagged results with that status.

module http_response_header_parser
    import hrhp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire hrhp_req_t byte_req,
    output logic           res_valid,
    input  wire logic      res_stall,
    output hrhp_res_t      res_data
);

    localparam logic [3:0] PH_SKIP0      = 4'd0;
    localparam logic [3:0] PH_VERSION    = 4'd1;
    localparam logic [3:0] PH_SKIP1      = 4'd2;
    localparam logic [3:0] PH_STATUS     = 4'd3;
    localparam logic [3:0] PH_SKIP2      = 4'd4;
    localparam logic [3:0] PH_REASON     = 4'd5;
    localparam logic [3:0] PH_REASON_CR  = 4'd6;
    localparam logic [3:0] PH_LINE_START = 4'd7;
    localparam logic [3:0] PH_NAME       = 4'd8;
    localparam logic [3:0] PH_OWS        = 4'd9;
    localparam logic [3:0] PH_VALUE      = 4'd10;
    localparam logic [3:0] PH_VALUE_CR   = 4'd11;
    localparam logic [3:0] PH_LINE_NEXT  = 4'd12;
    localparam logic [3:0] PH_END_CR     = 4'd13;
    localparam logic [3:0] PH_FINISHED   = 4'd14;

    logic [3:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [1:0]       status_reg, status_next;
    logic             res_valid_reg, res_valid_next;
    hrhp_res_t        res_reg, res_next;

    logic             accept;
    logic [7:0]       b;
    logic             at_end;

    logic             take_en;
    logic [2:0]       take_kind;
    logic [LEN_W-1:0] take_lim;
    logic [3:0]       take_phase;
    logic             fail;
    logic             done_ok;

    assign byte_stall = res_valid_reg & res_stall;
    assign accept     = byte_valid & ~byte_stall;
    assign b          = byte_req.data_byte;
    assign at_end     = byte_req.at_end;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        take_en    = 1'b0;
        take_kind  = KIND_NONE;
        take_lim   = NAME_MAX;
        take_phase = PH_NAME;
        fail       = 1'b0;
        done_ok    = 1'b0;
        res_next.token_kind = KIND_NONE;
        res_next.token_byte = 8'd0;
        res_next.pair_done  = 1'b0;
        res_next.parse_status = status_reg;

        unique case (phase_reg)
            PH_SKIP0, PH_SKIP1, PH_SKIP2:
            begin
                if (at_end)
                begin
                    fail = 1'b1;
                end
                else if (!is_ws(b))
                begin
                    len_next = '0;
                    take_en  = 1'b1;
                    if (phase_reg == PH_SKIP0)
                    begin
                        take_kind  = KIND_VERSION;
                        take_lim   = VERSION_MAX;
                        take_phase = PH_VERSION;
                    end
                    else if (phase_reg == PH_SKIP1)
                    begin
                        take_kind  = KIND_STATUS;
                        take_lim   = STATUS_MAX;
                        take_phase = PH_STATUS;
                    end
                    else
                    begin
                        take_kind  = KIND_REASON;
                        take_lim   = REASON_MAX;
                        take_phase = PH_REASON;
                    end
                end
            end
            PH_VERSION, PH_STATUS:
            begin
                if (at_end)
                begin
                    fail = 1'b1;
                end
                else if (is_ws(b))
                begin
                    len_next   = '0;
                    phase_next = (phase_reg == PH_VERSION) ? PH_SKIP1 : PH_SKIP2;
                end
                else
                begin
                    take_en = 1'b1;
                    if (phase_reg == PH_VERSION)
                    begin
                        take_kind  = KIND_VERSION;
                        take_lim   = VERSION_MAX;
                        take_phase = PH_VERSION;
                    end
                    else
                    begin
                        take_kind  = KIND_STATUS;
                        take_lim   = STATUS_MAX;
                        take_phase = PH_STATUS;
                    end
                end
            end
            PH_REASON:
            begin
                if (at_end)
                begin
                    fail = 1'b1;
                end
                else if (b == CH_CR)
                begin
                    phase_next = PH_REASON_CR;
                end
                else if (b == CH_LF)
                begin
                    phase_next = PH_LINE_START;
                end
                else
                begin
                    take_en    = 1'b1;
                    take_kind  = KIND_REASON;
                    take_lim   = REASON_MAX;
                    take_phase = PH_REASON;
                end
            end
            PH_REASON_CR:
            begin
                if (at_end)
                begin
                    done_ok = 1'b1;
                end
                else if (b == CH_LF)
                begin
                    phase_next = PH_LINE_START;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_LINE_START, PH_LINE_NEXT:
            begin
                if (at_end)
                begin
                    done_ok = 1'b1;
                    res_next.pair_done = (phase_reg == PH_LINE_NEXT);
                end
                else if ((phase_reg == PH_LINE_NEXT) && is_blank(b))
                begin
                    // continuation line, the blank belongs to the value
                    take_en    = 1'b1;
                    take_kind  = KIND_VALUE;
                    take_lim   = VALUE_MAX;
                    take_phase = PH_VALUE;
                end
                else
                begin
                    res_next.pair_done = (phase_reg == PH_LINE_NEXT);
                    if (b == CH_LF)
                    begin
                        done_ok = 1'b1;
                    end
                    else if (b == CH_CR)
                    begin
                        phase_next = PH_END_CR;
                    end
                    else if (b == CH_COLON)
                    begin
                        len_next   = '0;
                        phase_next = PH_OWS;
                    end
                    else
                    begin
                        len_next   = '0;
                        take_en    = 1'b1;
                        take_kind  = KIND_NAME;
                        take_lim   = NAME_MAX;
                        take_phase = PH_NAME;
                    end
                end
            end
            PH_NAME:
            begin
                if (at_end || (b == CH_CR) || (b == CH_LF))
                begin
                    fail = 1'b1;
                end
                else if (b == CH_COLON)
                begin
                    len_next   = '0;
                    phase_next = PH_OWS;
                end
                else
                begin
                    take_en    = 1'b1;
                    take_kind  = KIND_NAME;
                    take_lim   = NAME_MAX;
                    take_phase = PH_NAME;
                end
            end
            PH_OWS, PH_VALUE:
            begin
                if (at_end)
                begin
                    res_next.pair_done = 1'b1;
                    done_ok = 1'b1;
                end
                else if (b == CH_CR)
                begin
                    phase_next = PH_VALUE_CR;
                end
                else if (b == CH_LF)
                begin
                    phase_next = PH_LINE_NEXT;
                end
                else if (!((phase_reg == PH_OWS) && is_blank(b)))
                begin
                    take_en    = 1'b1;
                    take_kind  = KIND_VALUE;
                    take_lim   = VALUE_MAX;
                    take_phase = PH_VALUE;
                end
            end
            PH_VALUE_CR:
            begin
                if (at_end)
                begin
                    res_next.pair_done = 1'b1;
                    done_ok = 1'b1;
                end
                else if (b == CH_LF)
                begin
                    phase_next = PH_LINE_NEXT;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_END_CR:
            begin
                if (at_end || (b == CH_LF))
                begin
                    done_ok = 1'b1;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            default:
            begin
                // finished or unused phase: input ignored
            end
        endcase

        if (take_en)
        begin
            if (len_next < take_lim)
            begin
                res_next.token_kind = take_kind;
                res_next.token_byte = b;
                len_next   = len_next + 1'b1;
                phase_next = take_phase;
            end
            else
            begin
                fail = 1'b1;
            end
        end

        status_next = status_reg;
        if (fail)
        begin
            status_next = ST_ERROR;
            phase_next  = PH_FINISHED;
            len_next    = '0;
            res_next.token_kind = KIND_NONE;
            res_next.token_byte = 8'd0;
            res_next.pair_done  = 1'b0;
        end
        else if (done_ok)
        begin
            status_next = ST_OK;
            phase_next  = PH_FINISHED;
            len_next    = '0;
        end
        res_next.parse_status = status_next;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP0;
            len_reg       <= '0;
            status_reg    <= ST_PARSING;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                phase_reg  <= phase_next;
                len_reg    <= len_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

`default_nettype wire

### sv/hrhp_checker.sv
// hrhp_checker: port-level checks for http_response_header_parser, bound to the top
// depends on hrhp_pkg
`default_nettype none

module hrhp_checker
    import hrhp_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      res_valid,
    input wire logic      res_stall,
    input wire hrhp_res_t res_data
);

    logic       res_take;
    logic       done_reg;
    logic [1:0] final_reg;

    assign res_take = res_valid & ~res_stall;

    // remembers the first finished status handed out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            final_reg <= ST_PARSING;
        end
        else if (res_take && !done_reg && (res_data.parse_status != ST_PARSING))
        begin
            done_reg  <= 1'b1;
            final_reg <= res_data.parse_status;
        end
    end

    a_sticky_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_take && done_reg |->
            (res_data.parse_status == final_reg) && (res_data.token_kind == KIND_NONE)
            && !res_data.pair_done)
        else $error("finished status changed or result tagged after finish");

    a_error_untagged: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.parse_status == ST_ERROR) |->
            (res_data.token_kind == KIND_NONE) && !res_data.pair_done)
        else $error("error result carries a token or pair flag");

    a_none_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.token_kind == KIND_NONE) |-> (res_data.token_byte == 8'd0))
        else $error("untagged result has a nonzero byte");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result dropped or changed");

endmodule

bind http_response_header_parser hrhp_checker u_hrhp_checker (.*);

`default_nettype wire
